[rtl/olte_pkg.sv]
// Shared types and codes for the ordered list table engine.
// Transaction structs, opcode and status codes, internal command format.
// No dependencies.
`default_nettype none

package olte_pkg;

   // Field widths fixed by the transaction format
   localparam int OPCODE_W   = 2;
   localparam int KEY_W      = 31;
   localparam int AGE_W      = 31;
   localparam int POSITION_W = 7;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;

   // List capacity, tied to the index and count widths above
   localparam int CAPACITY = 64;

   // Queue depths between the stages
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [KEY_W-1:0]      key;
      logic [AGE_W-1:0]      new_age;
      logic [POSITION_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [COUNT_W-1:0]  entry_count;
      logic [AGE_W-1:0]    found_age;
   } rsp_type;

   // Command class decided in the front end
   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_FIND,
      KIND_UPDATE,
      KIND_REMOVE
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [KEY_W-1:0]      key;
      logic [AGE_W-1:0]      new_age;
      logic [POSITION_W-1:0] position;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/olte_fifo.sv]
// Small synchronous queue with full/empty flags and a type parameter.
// Used between front and back end, and as the result queue.
// Depends on nothing.
`default_nettype none

module olte_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic      full,
   input  item_type  push_data,
   input  wire logic pop,
   output logic      empty,
   output item_type  pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/olte_front.sv]
// Front end: input register stage that accepts request transactions and
// classifies the opcode into a command for the back end.
// Depends on olte_pkg.
`default_nettype none

module olte_front
   import olte_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_push,
   output logic      req_full,
   input  req_type   req_data,
   output logic      cmd_push,
   input  wire logic cmd_full,
   output cmd_type   cmd_data
);

   logic    valid_ff, valid_in;
   cmd_type item_ff, item_in;
   logic    accept;

   // Stage is blocked only when it holds a command the queue cannot take
   assign req_full = valid_ff && cmd_full;
   assign accept   = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;
   assign cmd_data = item_ff;

   // Opcode decode into command class
   always_comb begin
      item_in          = item_ff;
      item_in.key      = req_data.key;
      item_in.new_age  = req_data.new_age;
      item_in.position = req_data.position;
      unique case (req_data.opcode)
         OP_INSERT: item_in.kind = KIND_INSERT;
         OP_FIND:   item_in.kind = KIND_FIND;
         OP_UPDATE: item_in.kind = KIND_UPDATE;
         OP_REMOVE: item_in.kind = KIND_REMOVE;
         default:   item_in.kind = KIND_INSERT;
      endcase
      valid_in = accept || (valid_ff && cmd_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

[rtl/olte_back.sv]
// Back end: entry memories, fill count and the sequencer that scans and
// shifts entries one per cycle through a single read and write port.
// Depends on olte_pkg.
`default_nettype none

module olte_back
   import olte_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_empty,
   output logic      cmd_pop,
   input  cmd_type   cmd_data,
   input  wire logic rsp_full,
   output logic      rsp_push,
   output rsp_type   rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_INS_SHIFT,
      S_REM_SHIFT
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic             pend_ff, pend_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    hit_ff, hit_in;
   cmd_type          cmd_ff, cmd_in;

   // Entry memories with registered read
   logic [KEY_W-1:0] key_mem_ff [CAPACITY];
   logic [AGE_W-1:0] age_mem_ff [CAPACITY];
   logic [KEY_W-1:0] rd_key_ff;
   logic [AGE_W-1:0] rd_age_ff;

   logic             mem_re, mem_we;
   logic [AW-1:0]    mem_raddr, mem_waddr;
   logic [KEY_W-1:0] mem_wkey;
   logic [AGE_W-1:0] mem_wage;

   logic             ins_issue, scan_issue, key_hit, start;
   logic [CW-1:0]    rd_ptr_dec, rd_ptr_inc, pos_clamp;

   assign start      = !cmd_empty && !rsp_full;
   assign ins_issue  = rd_ptr_ff > pos_ff;
   assign scan_issue = rd_ptr_ff < count_ff;
   assign key_hit    = pend_ff && (rd_key_ff == cmd_ff.key);
   assign rd_ptr_dec = rd_ptr_ff - 1'b1;
   assign rd_ptr_inc = rd_ptr_ff + 1'b1;
   assign pos_clamp  = (PW'(cmd_data.position) > PW'(count_ff)) ? count_ff
                                                             : CW'(cmd_data.position);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_addr_in = wr_addr_ff;
      pend_in    = 1'b0;
      pos_in     = pos_ff;
      hit_in     = hit_ff;
      cmd_in     = cmd_ff;
      cmd_pop    = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wkey   = cmd_ff.key;
      mem_wage   = cmd_ff.new_age;
      rsp_push   = 1'b0;
      rsp_data             = '0;
      rsp_data.entry_count = COUNT_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd_data;
               rd_ptr_in = '0;
               if (cmd_data.kind == KIND_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_FULL;
                  end else begin
                     pos_in    = pos_clamp;
                     rd_ptr_in = count_ff;
                     state_in  = S_INS_SHIFT;
                  end
               end else if (cmd_data.kind != KIND_FIND && count_ff == '0) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = ST_EMPTY;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         // Move entries up from the end, then drop the new one in place
         S_INS_SHIFT: begin
            if (ins_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_ptr_dec[AW-1:0];
               rd_ptr_in  = rd_ptr_dec;
               wr_addr_in = rd_ptr_ff[AW-1:0];
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wkey  = rd_key_ff;
               mem_wage  = rd_age_ff;
            end else if (!ins_issue) begin
               mem_we               = 1'b1;
               mem_waddr            = pos_ff[AW-1:0];
               count_in             = count_ff + 1'b1;
               rsp_push             = 1'b1;
               rsp_data.status      = ST_OK;
               rsp_data.index       = INDEX_W'(pos_ff);
               rsp_data.entry_count = COUNT_W'(count_ff + 1'b1);
               state_in             = S_IDLE;
            end
         end

         // Scan from the bottom, compare against the registered read data
         S_SEARCH: begin
            if (scan_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_ptr_ff[AW-1:0];
               rd_ptr_in  = rd_ptr_inc;
               wr_addr_in = rd_ptr_ff[AW-1:0];
               pend_in    = 1'b1;
            end
            if (key_hit) begin
               unique case (cmd_ff.kind)
                  KIND_FIND: begin
                     rsp_push           = 1'b1;
                     rsp_data.index     = INDEX_W'(wr_addr_ff);
                     rsp_data.found_age = rd_age_ff;
                     state_in           = S_IDLE;
                  end
                  KIND_UPDATE: begin
                     mem_we         = 1'b1;
                     mem_waddr      = wr_addr_ff;
                     rsp_push       = 1'b1;
                     rsp_data.index = INDEX_W'(wr_addr_ff);
                     state_in       = S_IDLE;
                  end
                  default: begin
                     hit_in    = wr_addr_ff;
                     rd_ptr_in = CW'(wr_addr_ff) + 1'b1;
                     pend_in   = 1'b0;
                     state_in  = S_REM_SHIFT;
                  end
               endcase
            end else if (!pend_ff && !scan_issue) begin
               rsp_push        = 1'b1;
               rsp_data.status = ST_NOT_FOUND;
               state_in        = S_IDLE;
            end
         end

         // Move entries above the hit down by one
         S_REM_SHIFT: begin
            if (scan_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_ptr_ff[AW-1:0];
               rd_ptr_in  = rd_ptr_inc;
               wr_addr_in = rd_ptr_dec[AW-1:0];
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wkey  = rd_key_ff;
               mem_wage  = rd_age_ff;
            end else if (!scan_issue) begin
               count_in             = count_ff - 1'b1;
               rsp_push             = 1'b1;
               rsp_data.index       = INDEX_W'(hit_ff);
               rsp_data.entry_count = COUNT_W'(count_ff - 1'b1);
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      rd_ptr_ff  <= rd_ptr_in;
      wr_addr_ff <= wr_addr_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      cmd_ff     <= cmd_in;
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem_ff[mem_waddr] <= mem_wkey;
         age_mem_ff[mem_waddr] <= mem_wage;
      end
      if (mem_re) begin
         rd_key_ff <= key_mem_ff[mem_raddr];
         rd_age_ff <= age_mem_ff[mem_raddr];
      end
   end

endmodule

`default_nettype wire

[rtl/ordered_list_table_engine.sv]
// Top level of the ordered list table engine: front end, command queue,
// back end and result queue. Depends on olte_pkg, olte_front, olte_fifo,
// olte_back.
//
//   channel   ports                          direction  payload
//   request   req_push / req_full / req_data  in         req_type
//   response  rsp_pop / rsp_empty / rsp_data  out        rsp_type
//
// One transaction at a time in the back end, one entry per cycle through the
// single read port and single write port. A request passes the front register
// and the command queue on its way to the back end. Reset clears the fill count
// and control state only. Two-entry queues let either side stall.
`default_nettype none

module ordered_list_table_engine
   import olte_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_push,
   output logic      req_full,
   input  req_type   req_data,
   output logic      rsp_empty,
   input  wire logic rsp_pop,
   output rsp_type   rsp_data
);

   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_wdata, cmd_rdata;
   logic    rsp_push, rsp_full;
   rsp_type rsp_wdata;

   olte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_wdata)
   );

   olte_fifo #(
      .item_type (cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (cmd_wdata),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_rdata)
   );

   olte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   olte_fifo #(
      .item_type (rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_data (rsp_wdata),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/olte_checker.sv]
// Port-level checks for the ordered list table engine, bound to the top.
// Depends on olte_pkg and ordered_list_table_engine.
`default_nettype none

module olte_checker
   import olte_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_full,
   input wire logic rsp_empty,
   input wire logic rsp_pop,
   input rsp_type   rsp_data
);

   // After reset the request side is not full and the result queue is empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not cleared by reset");

   // A waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response changed while waiting");

   // Failed transactions report index zero
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |-> (rsp_data.index == '0))
      else $error("nonzero index on failed transaction");

   // A nonzero age only comes with an OK status
   a_age_only_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.found_age != '0) |-> (rsp_data.status == ST_OK))
      else $error("age reported on failed transaction");

   // Empty status only when the list holds nothing
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_EMPTY) |-> (rsp_data.entry_count == '0))
      else $error("empty status with entries present");

endmodule

bind ordered_list_table_engine olte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[dv/ordered_list_table_engine_test.sv]
// Self-checking testbench for ordered_list_table_engine: directed table, then
// random operation mixes, checked against the table's written responses or
// a cycle-free list predictor. Depends on olte_pkg and the engine RTL.
`default_nettype none

module ordered_list_table_engine_test;
   import olte_pkg::*;

   localparam int LIST_CAP     = CAPACITY;
   localparam int GEN_COPY     = 0;        // list copy tracked while building stimulus
   localparam int CHK_COPY     = 1;        // list copy advanced on accepted requests
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_AT      = 40;       // accepted requests before the long pop stall
   localparam int HOLD_CYCLES  = 1000;
   localparam int TAIL_CYCLES  = 200;
   localparam int REPORT_MAX   = 10;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   typedef struct {
      req_type rq;
      bit      typed;    // expected response written in the table
      rsp_type rs;
   } stim_row;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    rsp_pop  = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   // Two copies of the list: one for stimulus shaping, one for checking
   logic [KEY_W-1:0]   list_key  [2][LIST_CAP];
   logic [AGE_W-1:0]   list_age  [2][LIST_CAP];
   logic [COUNT_W-1:0] list_fill [2];

   stim_row     stim_q[$];
   rsp_type     expected_q[$];
   int unsigned total_items     = 0;
   int unsigned directed_items  = 0;
   int unsigned items_accepted  = 0;
   int unsigned rsp_checked     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned full_hits       = 0;
   int unsigned empty_hits      = 0;
   bit          req_taken       = 1'b0;
   bit          hold_done       = 1'b0;

   ordered_list_table_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   // Apply one operation to list copy m and return the response it produces
   function automatic rsp_type apply_list_op(input int m, input req_type rq);
      rsp_type     rs;
      int unsigned slot;
      int unsigned hit;
      int unsigned i;
      rs = '0;
      rs.status = ST_OK;
      if (rq.opcode == OP_INSERT) begin
         if (list_fill[m] >= LIST_CAP) begin
            rs.status = ST_FULL;
         end else begin
            slot = (rq.position > list_fill[m]) ? list_fill[m] : rq.position;
            for (i = list_fill[m]; i > slot; i--) begin
               list_key[m][i] = list_key[m][i-1];
               list_age[m][i] = list_age[m][i-1];
            end
            list_key[m][slot] = rq.key;
            list_age[m][slot] = rq.new_age;
            list_fill[m] = list_fill[m] + 1'b1;
            rs.index = slot[INDEX_W-1:0];
         end
      end else begin
         // lowest matching slot, or the fill count on a miss
         hit = list_fill[m];
         for (i = 0; i < list_fill[m]; i++) begin
            if (hit == list_fill[m] && list_key[m][i] == rq.key) hit = i;
         end
         if (rq.opcode != OP_FIND && list_fill[m] == 0) begin
            rs.status = ST_EMPTY;
         end else if (hit >= list_fill[m]) begin
            rs.status = ST_NOT_FOUND;
         end else begin
            rs.index = hit[INDEX_W-1:0];
            case (rq.opcode)
               OP_FIND: begin
                  rs.found_age = list_age[m][hit];
               end
               OP_UPDATE: begin
                  list_age[m][hit] = rq.new_age;
               end
               default: begin
                  for (i = hit; i + 1 < list_fill[m]; i++) begin
                     list_key[m][i] = list_key[m][i+1];
                     list_age[m][i] = list_age[m][i+1];
                  end
                  list_fill[m] = list_fill[m] - 1'b1;
               end
            endcase
         end
      end
      rs.entry_count = list_fill[m];
      return rs;
   endfunction

   function automatic req_type mk_req(input logic [OPCODE_W-1:0] op,
                                      input logic [KEY_W-1:0] key,
                                      input logic [AGE_W-1:0] age,
                                      input logic [POSITION_W-1:0] pos);
      req_type rq;
      rq.opcode   = op;
      rq.key      = key;
      rq.new_age  = age;
      rq.position = pos;
      return rq;
   endfunction

   function automatic rsp_type mk_rsp(input logic [STATUS_W-1:0] st,
                                      input logic [INDEX_W-1:0] idx,
                                      input logic [COUNT_W-1:0] cnt,
                                      input logic [AGE_W-1:0] age);
      rsp_type rs;
      rs.status      = st;
      rs.index       = idx;
      rs.entry_count = cnt;
      rs.found_age   = age;
      return rs;
   endfunction

   // Queue one request and advance the stimulus copy of the list
   task automatic add_item(input req_type rq, input bit typed, input rsp_type rs);
      rsp_type unused;
      unused = apply_list_op(GEN_COPY, rq);
      stim_q.push_back('{rq, typed, rs});
      total_items++;
   endtask

   // Mostly keys already in the list, some from a small pool, some anywhere
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (list_fill[GEN_COPY] != 0 && roll < 60)
         return list_key[GEN_COPY][$urandom_range(0, list_fill[GEN_COPY] - 1)];
      else if (roll < 80)
         return KEY_W'($urandom_range(0, 15));
      else
         return KEY_W'($urandom);
   endfunction

   function automatic logic [POSITION_W-1:0] pick_position();
      if ($urandom_range(0, 3) == 0) return POSITION_W'($urandom_range(0, 127));
      return POSITION_W'($urandom_range(0, list_fill[GEN_COPY]));
   endfunction

   // Operation mix leans toward inserts on a sparse list, removes on a dense one
   task automatic add_mixed(input int unsigned count);
      int unsigned n;
      int unsigned roll;
      int unsigned ins_pct;
      logic [OPCODE_W-1:0] op;
      for (n = 0; n < count; n++) begin
         ins_pct = (list_fill[GEN_COPY] < 16) ? 60 : (list_fill[GEN_COPY] > 56) ? 15 : 35;
         roll = $urandom_range(0, 99);
         if (roll < ins_pct)
            op = OP_INSERT;
         else if (roll < ins_pct + (100 - ins_pct) / 3)
            op = OP_FIND;
         else if (roll < ins_pct + 2 * (100 - ins_pct) / 3)
            op = OP_UPDATE;
         else
            op = OP_REMOVE;
         add_item(mk_req(op, pick_key(), AGE_W'($urandom), pick_position()), 1'b0, '0);
      end
   endtask

   task automatic build_stimulus();
      stim_row     directed [19];
      int unsigned n;
      // directed table: empty list, extremes, duplicates, misses
      directed[0]  = '{mk_req(OP_FIND, 5, 0, 0), 1'b1, mk_rsp(ST_NOT_FOUND, 0, 0, 0)};
      directed[1]  = '{mk_req(OP_UPDATE, 5, 7, 0), 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0)};
      directed[2]  = '{mk_req(OP_REMOVE, 5, 0, 0), 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0)};
      directed[3]  = '{mk_req(OP_INSERT, KEY_MAX, AGE_MAX, 7'd127), 1'b1,
                       mk_rsp(ST_OK, 0, 1, 0)};
      directed[4]  = '{mk_req(OP_INSERT, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 2, 0)};
      directed[5]  = '{mk_req(OP_FIND, KEY_MAX, 0, 0), 1'b1, mk_rsp(ST_OK, 1, 2, AGE_MAX)};
      directed[6]  = '{mk_req(OP_FIND, 0, AGE_MAX, 7'd127), 1'b1, mk_rsp(ST_OK, 0, 2, 0)};
      directed[7]  = '{mk_req(OP_INSERT, 0, 123, 64), 1'b1, mk_rsp(ST_OK, 2, 3, 0)};
      directed[8]  = '{mk_req(OP_FIND, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 3, 0)};
      directed[9]  = '{mk_req(OP_UPDATE, 0, 55, 0), 1'b1, mk_rsp(ST_OK, 0, 3, 0)};
      directed[10] = '{mk_req(OP_FIND, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 3, 55)};
      directed[11] = '{mk_req(OP_REMOVE, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 2, 0)};
      directed[12] = '{mk_req(OP_FIND, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 1, 2, 123)};
      directed[13] = '{mk_req(OP_UPDATE, 12345, 9, 0), 1'b1, mk_rsp(ST_NOT_FOUND, 0, 2, 0)};
      directed[14] = '{mk_req(OP_REMOVE, 12345, 0, 0), 1'b1, mk_rsp(ST_NOT_FOUND, 0, 2, 0)};
      directed[15] = '{mk_req(OP_INSERT, 1, 1, 1), 1'b0, '0};
      directed[16] = '{mk_req(OP_FIND, 1, 0, 0), 1'b0, '0};
      directed[17] = '{mk_req(OP_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, 3), 1'b0, '0};
      directed[18] = '{mk_req(OP_REMOVE, KEY_MAX, 0, 0), 1'b0, '0};
      foreach (directed[i]) add_item(directed[i].rq, directed[i].typed, directed[i].rs);
      directed_items = total_items;

      // fill to capacity, then push against the full list
      while (list_fill[GEN_COPY] < LIST_CAP)
         add_item(mk_req(OP_INSERT, pick_key(), AGE_W'($urandom), pick_position()),
                  1'b0, '0);
      for (n = 0; n < 6; n++)
         add_item(mk_req(OP_INSERT, KEY_W'($urandom), AGE_W'($urandom),
                         POSITION_W'($urandom_range(0, 127))), 1'b0, '0);

      add_mixed(400);

      // drain to empty with some misses in between, then hit the empty list
      while (list_fill[GEN_COPY] != 0) begin
         if ($urandom_range(0, 9) == 0)
            add_item(mk_req(OP_FIND, KEY_W'($urandom), 0, 0), 1'b0, '0);
         else
            add_item(mk_req(OP_REMOVE, list_key[GEN_COPY][$urandom_range(0,
                            list_fill[GEN_COPY] - 1)], AGE_W'($urandom), 0), 1'b0, '0);
      end
      add_item(mk_req(OP_UPDATE, KEY_W'($urandom), AGE_W'($urandom), 0), 1'b0, '0);
      add_item(mk_req(OP_REMOVE, KEY_W'($urandom), 0, 0), 1'b0, '0);
      add_item(mk_req(OP_FIND, KEY_W'($urandom), 0, 0), 1'b0, '0);

      add_mixed(450);
   endtask

   // Idle phase from progress: thirds of the run
   function automatic int unsigned idle_phase();
      return (items_accepted * 3) / (total_items == 0 ? 1 : total_items);
   endfunction

   // Request driver: offer the head of the stimulus queue at random
   initial begin : drive_requests
      int unsigned idle_pct;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (req_push && req_taken) void'(stim_q.pop_front());
         case (idle_phase())
            0:       idle_pct = 38;
            1:       idle_pct = 54;
            default: idle_pct = 0;
         endcase
         if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_push <= 1'b1;
            req_data <= stim_q[0].rq;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Response driver, with one long stall to back the engine up
   initial begin : drive_pops
      int unsigned idle_pct;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && items_accepted >= HOLD_AT) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         case (idle_phase())
            0:       idle_pct = 54;
            1:       idle_pct = 38;
            default: idle_pct = 0;
         endcase
         rsp_pop <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("unexpected response: status %0d index %0d count %0d age %0h",
                     got.status, got.index, got.entry_count, got.found_age);
         return;
      end
      want = expected_q.pop_front();
      rsp_checked++;
      if (got.status != want.status || got.index != want.index ||
          got.entry_count != want.entry_count || got.found_age != want.found_age) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX) begin
            $display("response %0d mismatch: exp st %0d idx %0d cnt %0d age %0h",
                     rsp_checked, want.status, want.index, want.entry_count,
                     want.found_age);
            $display("   got st %0d idx %0d cnt %0d age %0h",
                     got.status, got.index, got.entry_count, got.found_age);
         end
      end
   endtask

   // Port monitor: predict on each accepted request, check each popped response
   always @(posedge clock) begin : watch_ports
      rsp_type predicted;
      req_taken = 1'b0;
      if (!reset && req_push && !req_full) begin
         req_taken = 1'b1;
         predicted = apply_list_op(CHK_COPY, req_data);
         if (predicted.status == ST_FULL) full_hits++;
         if (predicted.status == ST_EMPTY) empty_hits++;
         expected_q.push_back(stim_q[0].typed ? stim_q[0].rs : predicted);
         items_accepted++;
      end
      if (!reset && rsp_pop && !rsp_empty) check_response(rsp_data);
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : run_test
      list_fill[GEN_COPY] = '0;
      list_fill[CHK_COPY] = '0;
      build_stimulus();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (items_accepted != total_items) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d requests (%0d directed), %0d responses checked, %0d mismatches",
               total_items, directed_items, rsp_checked, mismatch_count);
      $display("inserts refused on a full list: %0d, updates/removes on an empty list: %0d",
               full_hits, empty_hits);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/olte_pkg.sv
rtl/olte_fifo.sv
rtl/olte_front.sv
rtl/olte_back.sv
rtl/ordered_list_table_engine.sv
rtl/olte_checker.sv
dv/ordered_list_table_engine_test.sv
